// ----- rtl/swmm_pkg.sv -----
// ----------------------------------------------------------------------------
// swmm_pkg - shared definitions for the sliding window min/max block
// Sample width, register map, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package swmm_pkg;

   localparam int SAMPLE_W       = 32;
   localparam int COUNT_W        = 32;
   localparam int PERIOD_W       = 9;
   localparam int MAX_PERIOD_DEF = 256;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] ADDR_PERIOD  = 2'd0;
   localparam logic [PERIOD_W-1:0]   PERIOD_RESET = 9'd30;

   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic                written;
   } cfg_type;

endpackage

// ----- rtl/sliding_window_min_max.sv -----
// ----------------------------------------------------------------------------
// sliding_window_min_max - running minimum and maximum over a sample window
// Requests are taken one per cycle while the window fills. Once results flow,
// a request goes from S_IDLE to S_EMIT, via S_SCAN and S_NEWEST when a cached
// extreme is stale or has left the window and a rescan through the single read
// port of the sample ring is needed; S_EMIT registers the result once the output
// register is free, and req_stall holds off new requests until S_IDLE is reached.
// Reset clears counters and cached extremes; the ring itself is not cleared.
// ----------------------------------------------------------------------------
module sliding_window_min_max #(
   parameter int MAX_PERIOD = swmm_pkg::MAX_PERIOD_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [swmm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_first,
   input  logic                                 req_final_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [swmm_pkg::SAMPLE_W-1:0] rsp_window_min,
   output logic signed [swmm_pkg::SAMPLE_W-1:0] rsp_window_max,
   output logic [swmm_pkg::COUNT_W-1:0]         rsp_position,
   output logic                                 rsp_end_of_run,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [swmm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [swmm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [swmm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import swmm_pkg::*;

   localparam int SLOT_W = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
   localparam int P_W    = $clog2(MAX_PERIOD + 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_NEWEST, S_EMIT} state_type;

   cfg_type cfg;

   state_type                  state_ff, state_in;
   logic [SLOT_W-1:0]          write_slot_ff, write_slot_in;
   logic [P_W-1:0]             fill_ff, fill_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic signed [SAMPLE_W-1:0] max_val_ff, max_val_in;
   logic signed [SAMPLE_W-1:0] min_val_ff, min_val_in;
   logic [P_W-1:0]             max_age_ff, max_age_in;
   logic [P_W-1:0]             min_age_ff, min_age_in;
   logic                       max_live_ff, max_live_in;
   logic                       min_live_ff, min_live_in;
   logic                       scan_max_ff, scan_max_in;
   logic                       scan_min_ff, scan_min_in;
   logic                       seeded_ff, seeded_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [COUNT_W-1:0]         pos_ff, pos_in;
   logic                       last_ff, last_in;
   logic [P_W-1:0]             reads_left_ff, reads_left_in;
   logic [SLOT_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [P_W-1:0]             rd_age_ff, rd_age_in;
   logic                       data_valid_ff, data_valid_in;
   logic [P_W-1:0]             data_age_ff, data_age_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_min_ff, rsp_min_in;
   logic signed [SAMPLE_W-1:0] rsp_max_ff, rsp_max_in;
   logic [COUNT_W-1:0]         rsp_pos_ff, rsp_pos_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [P_W-1:0]             p_eff;
   logic [SLOT_W-1:0]          slot_e;
   logic [P_W-1:0]             fill_e, fill_new;
   logic [COUNT_W-1:0]         cnt_e;
   logic                       max_live_e, min_live_e;
   logic [P_W-1:0]             max_age_inc, min_age_inc;
   logic                       max_keep, min_keep;
   logic [P_W:0]               newest_x, pm1_x, start_x;
   logic [SLOT_W-1:0]          start_slot;

   logic                       ring_wr_en, ring_rd_en;
   logic signed [SAMPLE_W-1:0] ring_rd_data;

   logic                       fold_en;
   logic signed [SAMPLE_W-1:0] fold_val;
   logic [P_W-1:0]             fold_age;

   swmm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   swmm_ring #(
      .DEPTH  (MAX_PERIOD),
      .ADDR_W (SLOT_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (slot_e),
      .wr_data (req_sample),
      .rd_en   (ring_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ring_rd_data)
   );

   // effective period and start-of-series view of the counters
   always_comb begin
      if (cfg.period == '0) begin
         p_eff = P_W'(1);
      end else if (32'(cfg.period) > 32'(MAX_PERIOD)) begin
         p_eff = P_W'(MAX_PERIOD);
      end else begin
         p_eff = P_W'(cfg.period);
      end

      slot_e     = req_first ? '0 : write_slot_ff;
      fill_e     = req_first ? '0 : fill_ff;
      cnt_e      = req_first ? '0 : count_ff;
      max_live_e = req_first ? 1'b0 : max_live_ff;
      min_live_e = req_first ? 1'b0 : min_live_ff;

      fill_new    = (fill_e == P_W'(MAX_PERIOD)) ? fill_e : fill_e + P_W'(1);
      max_age_inc = max_age_ff + P_W'(1);
      min_age_inc = min_age_ff + P_W'(1);
      max_keep    = max_live_e && (max_age_inc < p_eff);
      min_keep    = min_live_e && (min_age_inc < p_eff);

      // oldest slot of the window: newest - (p - 1), modulo ring depth
      newest_x = (P_W+1)'(slot_e);
      pm1_x    = (P_W+1)'(p_eff - P_W'(1));
      if (newest_x >= pm1_x) begin
         start_x = newest_x - pm1_x;
      end else begin
         start_x = newest_x + (P_W+1)'(MAX_PERIOD) - pm1_x;
      end
      start_slot = SLOT_W'(start_x);

      fold_en  = ((state_ff == S_SCAN) && data_valid_ff) || (state_ff == S_NEWEST);
      fold_val = (state_ff == S_NEWEST) ? sample_ff : ring_rd_data;
      fold_age = (state_ff == S_NEWEST) ? '0 : data_age_ff;
   end

   always_comb begin
      state_in      = state_ff;
      write_slot_in = write_slot_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      max_val_in    = max_val_ff;
      min_val_in    = min_val_ff;
      max_age_in    = max_age_ff;
      min_age_in    = min_age_ff;
      max_live_in   = max_live_ff;
      min_live_in   = min_live_ff;
      scan_max_in   = scan_max_ff;
      scan_min_in   = scan_min_ff;
      seeded_in     = seeded_ff;
      sample_in     = sample_ff;
      pos_in        = pos_ff;
      last_in       = last_ff;
      reads_left_in = reads_left_ff;
      rd_ptr_in     = rd_ptr_ff;
      rd_age_in     = rd_age_ff;
      data_valid_in = 1'b0;
      data_age_in   = data_age_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_min_in    = rsp_min_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_last_in   = rsp_last_ff;
      ring_wr_en    = 1'b0;
      ring_rd_en    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ring_wr_en    = 1'b1;
               write_slot_in = (slot_e == SLOT_W'(MAX_PERIOD - 1)) ? '0 :
                               slot_e + SLOT_W'(1);
               fill_in       = fill_new;
               count_in      = (cnt_e == '1) ? cnt_e : cnt_e + COUNT_W'(1);
               sample_in     = req_sample;
               pos_in        = cnt_e;
               last_in       = req_final_sample;
               max_live_in   = max_live_e;
               min_live_in   = min_live_e;
               if (fill_new >= p_eff) begin
                  max_live_in = 1'b1;
                  min_live_in = 1'b1;
                  scan_max_in = !max_keep;
                  scan_min_in = !min_keep;
                  if (max_keep) begin
                     if (!(req_sample < max_val_ff)) begin
                        max_val_in = req_sample;
                        max_age_in = '0;
                     end else begin
                        max_age_in = max_age_inc;
                     end
                  end
                  if (min_keep) begin
                     if (!(min_val_ff < req_sample)) begin
                        min_val_in = req_sample;
                        min_age_in = '0;
                     end else begin
                        min_age_in = min_age_inc;
                     end
                  end
                  if (!max_keep || !min_keep) begin
                     state_in      = S_SCAN;
                     reads_left_in = p_eff - P_W'(1);
                     rd_age_in     = p_eff - P_W'(1);
                     rd_ptr_in     = start_slot;
                     seeded_in     = 1'b0;
                  end else begin
                     state_in = S_EMIT;
                  end
               end
            end
         end
         S_SCAN: begin
            if (reads_left_ff != '0) begin
               ring_rd_en    = 1'b1;
               rd_ptr_in     = (rd_ptr_ff == SLOT_W'(MAX_PERIOD - 1)) ? '0 :
                               rd_ptr_ff + SLOT_W'(1);
               rd_age_in     = rd_age_ff - P_W'(1);
               reads_left_in = reads_left_ff - P_W'(1);
               data_valid_in = 1'b1;
               data_age_in   = rd_age_ff;
            end else begin
               state_in = S_NEWEST;
            end
         end
         S_NEWEST: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_min_in   = min_val_ff;
               rsp_max_in   = max_val_ff;
               rsp_pos_in   = pos_ff;
               rsp_last_in  = last_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // rescan fold, oldest to newest; earliest sample kept on a tie
      if (fold_en) begin
         seeded_in = 1'b1;
         if (scan_max_ff && (!seeded_ff || (max_val_ff < fold_val))) begin
            max_val_in = fold_val;
            max_age_in = fold_age;
         end
         if (scan_min_ff && (!seeded_ff || (fold_val < min_val_ff))) begin
            min_val_in = fold_val;
            min_age_in = fold_age;
         end
      end

      if (cfg.written) begin
         max_live_in = 1'b0;
         min_live_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         write_slot_ff <= '0;
         fill_ff       <= '0;
         count_ff      <= '0;
         max_val_ff    <= '0;
         min_val_ff    <= '0;
         max_age_ff    <= '0;
         min_age_ff    <= '0;
         max_live_ff   <= 1'b0;
         min_live_ff   <= 1'b0;
         scan_max_ff   <= 1'b0;
         scan_min_ff   <= 1'b0;
         seeded_ff     <= 1'b0;
         reads_left_ff <= '0;
         data_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         write_slot_ff <= write_slot_in;
         fill_ff       <= fill_in;
         count_ff      <= count_in;
         max_val_ff    <= max_val_in;
         min_val_ff    <= min_val_in;
         max_age_ff    <= max_age_in;
         min_age_ff    <= min_age_in;
         max_live_ff   <= max_live_in;
         min_live_ff   <= min_live_in;
         scan_max_ff   <= scan_max_in;
         scan_min_ff   <= scan_min_in;
         seeded_ff     <= seeded_in;
         reads_left_ff <= reads_left_in;
         data_valid_ff <= data_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      pos_ff      <= pos_in;
      last_ff     <= last_in;
      rd_ptr_ff   <= rd_ptr_in;
      rd_age_ff   <= rd_age_in;
      data_age_ff <= data_age_in;
      rsp_min_ff  <= rsp_min_in;
      rsp_max_ff  <= rsp_max_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_min = rsp_min_ff;
   assign rsp_window_max = rsp_max_ff;
   assign rsp_position   = rsp_pos_ff;
   assign rsp_end_of_run = rsp_last_ff;

endmodule

// ----- rtl/swmm_ring.sv -----
// ----------------------------------------------------------------------------
// swmm_ring - sample ring memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module swmm_ring #(
   parameter int DEPTH  = swmm_pkg::MAX_PERIOD_DEF,
   parameter int ADDR_W = 8
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [ADDR_W-1:0]                    wr_addr,
   input  logic signed [swmm_pkg::SAMPLE_W-1:0] wr_data,
   input  logic                                 rd_en,
   input  logic [ADDR_W-1:0]                    rd_addr,
   output logic signed [swmm_pkg::SAMPLE_W-1:0] rd_data
);
   import swmm_pkg::*;

   logic signed [SAMPLE_W-1:0] mem_ff [DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/swmm_csr.sv -----
// ----------------------------------------------------------------------------
// swmm_csr - configuration register port
// APB-style access to the period register; flags each period write.
// ----------------------------------------------------------------------------
module swmm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [swmm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [swmm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [swmm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output swmm_pkg::cfg_type                   cfg
);
   import swmm_pkg::*;

   logic [PERIOD_W-1:0] period_ff;
   logic [PERIOD_W-1:0] period_in;
   logic                period_wr;

   assign csr_pready = 1'b1;
   assign period_wr  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr == ADDR_PERIOD);
   assign period_in  = period_wr ? csr_pwdata[PERIOD_W-1:0] : period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else begin
         period_ff <= period_in;
      end
   end

   assign csr_prdata  = (csr_paddr == ADDR_PERIOD) ? CSR_DATA_W'(period_ff) : '0;
   assign cfg.period  = period_ff;
   assign cfg.written = period_wr;

endmodule

// ----- dv/swmm_window_checker.sv -----
// ----------------------------------------------------------------------------
// swmm_window_checker - scoreboard for the sliding window min/max block
// Follows every accepted request and period write, keeps its own sample ring
// and cached extremes, queues the expected window result and compares each
// accepted result with the oldest one, field by field. Period reads are
// checked against the last value written, or the reset value before any write.
// ----------------------------------------------------------------------------
module swmm_window_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic signed [swmm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_first,
   input  logic                                 req_final_sample,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [swmm_pkg::SAMPLE_W-1:0] rsp_window_min,
   input  logic signed [swmm_pkg::SAMPLE_W-1:0] rsp_window_max,
   input  logic [swmm_pkg::COUNT_W-1:0]         rsp_position,
   input  logic                                 rsp_end_of_run,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [swmm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [swmm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   input  logic [swmm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   input  logic                                 csr_pready,
   output int                                   failures,
   output int                                   pending,
   output int                                   results_seen
);

   timeunit 1ns;
   timeprecision 1ps;

   import swmm_pkg::*;

   localparam int MAX_WIN = MAX_PERIOD_DEF;
   localparam int SLOT_W  = $clog2(MAX_WIN);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] lo;
      logic signed [SAMPLE_W-1:0] hi;
      logic [COUNT_W-1:0]         index;
      logic                       last;
   } window_result_type;

   logic signed [SAMPLE_W-1:0] ring [MAX_WIN];
   logic [SLOT_W-1:0]          wr_slot;
   int                         filled;
   logic [COUNT_W-1:0]         next_index;
   logic signed [SAMPLE_W-1:0] hi_val;
   logic signed [SAMPLE_W-1:0] lo_val;
   int                         hi_age;
   int                         lo_age;
   bit                         hi_live;
   bit                         lo_live;
   logic [PERIOD_W-1:0]        win_cfg;
   window_result_type          due_extremes[$];

   task automatic log_failure(input string msg);
      failures++;
      if (failures <= 10)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic advance_window(input logic signed [SAMPLE_W-1:0] smp,
                                 input logic first_in, input logic last_in);
      int                         p;
      logic [SLOT_W-1:0]          newest;
      logic [SLOT_W-1:0]          slot;
      logic [COUNT_W-1:0]         idx;
      bit                         scan_hi;
      bit                         scan_lo;
      logic signed [SAMPLE_W-1:0] v;
      window_result_type          r;
      p = (win_cfg == '0) ? 1 : (win_cfg > MAX_WIN) ? MAX_WIN : int'(win_cfg);
      if (first_in) begin
         wr_slot    = '0;
         filled     = 0;
         next_index = '0;
         hi_live    = 1'b0;
         lo_live    = 1'b0;
      end
      newest       = wr_slot;
      ring[newest] = smp;
      wr_slot      = newest + 1'b1;
      idx          = next_index;
      if (next_index != '1)
         next_index++;
      if (filled < MAX_WIN)
         filled++;
      if (filled < p)
         return;

      if (hi_live) begin
         hi_age++;
         if (hi_age >= p)
            hi_live = 1'b0;
      end
      if (lo_live) begin
         lo_age++;
         if (lo_age >= p)
            lo_live = 1'b0;
      end

      // rescan oldest to newest, strict compare keeps the earliest on a tie
      scan_hi = !hi_live;
      scan_lo = !lo_live;
      slot = newest - SLOT_W'(p - 1);
      if (scan_hi) begin
         hi_val = ring[slot];
         hi_age = p - 1;
      end
      if (scan_lo) begin
         lo_val = ring[slot];
         lo_age = p - 1;
      end
      for (int a = p - 1; a > 0; a--) begin
         slot = newest - SLOT_W'(a - 1);
         v    = ring[slot];
         if (scan_hi && v > hi_val) begin
            hi_val = v;
            hi_age = a - 1;
         end
         if (scan_lo && v < lo_val) begin
            lo_val = v;
            lo_age = a - 1;
         end
      end
      if (!scan_hi && smp >= hi_val) begin
         hi_val = smp;
         hi_age = 0;
      end
      if (!scan_lo && smp <= lo_val) begin
         lo_val = smp;
         lo_age = 0;
      end
      hi_live = 1'b1;
      lo_live = 1'b1;

      r.lo    = lo_val;
      r.hi    = hi_val;
      r.index = idx;
      r.last  = last_in;
      due_extremes.push_back(r);
   endtask

   always @(posedge clock) begin : watch
      window_result_type want;
      if (reset) begin
         wr_slot    = '0;
         filled     = 0;
         next_index = '0;
         hi_val     = '0;
         lo_val     = '0;
         hi_age     = 0;
         lo_age     = 0;
         hi_live    = 1'b0;
         lo_live    = 1'b0;
         win_cfg    = PERIOD_RESET;
         due_extremes.delete();
         pending    = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (due_extremes.size() == 0) begin
               log_failure($sformatf("unexpected result min %h max %h position %0d",
                                     rsp_window_min, rsp_window_max, rsp_position));
            end else begin
               want = due_extremes.pop_front();
               if (rsp_window_min !== want.lo)
                  log_failure($sformatf("position %0d window_min expected %h got %h",
                                        want.index, want.lo, rsp_window_min));
               if (rsp_window_max !== want.hi)
                  log_failure($sformatf("position %0d window_max expected %h got %h",
                                        want.index, want.hi, rsp_window_max));
               if (rsp_position !== want.index)
                  log_failure($sformatf("position expected %0d got %0d",
                                        want.index, rsp_position));
               if (rsp_end_of_run !== want.last)
                  log_failure($sformatf("position %0d end_of_run expected %b got %b",
                                        want.index, want.last, rsp_end_of_run));
            end
         end
         if (req_valid && !req_stall)
            advance_window(req_sample, req_first, req_final_sample);
         if (csr_psel && csr_penable && csr_pready && csr_paddr == ADDR_PERIOD) begin
            if (csr_pwrite) begin
               win_cfg = csr_pwdata[PERIOD_W-1:0];
               hi_live = 1'b0;
               lo_live = 1'b0;
            end else if (csr_prdata !== CSR_DATA_W'(win_cfg)) begin
               log_failure($sformatf("period read expected %h got %h",
                                     CSR_DATA_W'(win_cfg), csr_prdata));
            end
         end
         pending = due_extremes.size();
      end
   end

endmodule

// ----- dv/tb_sliding_window_min_max.sv -----
// ----------------------------------------------------------------------------
// tb_sliding_window_min_max - testbench for the sliding window min/max block
// Drives sample requests and period writes, with random idling on both
// channels and one long output hold-off; a directed run of corner samples
// comes first, then random series over period settings from 1 to 511.
// Checking is done by swmm_window_checker alongside the block.
// ----------------------------------------------------------------------------
module tb_sliding_window_min_max;

   timeunit 1ns;
   timeprecision 1ps;

   import swmm_pkg::*;

   localparam int SETTLE      = MAX_PERIOD_DEF + 16;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 4000;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample       = '0;
   logic                       req_first        = 1'b0;
   logic                       req_final_sample = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall        = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_window_min;
   logic signed [SAMPLE_W-1:0] rsp_window_max;
   logic [COUNT_W-1:0]         rsp_position;
   logic                       rsp_end_of_run;
   logic                       csr_psel         = 1'b0;
   logic                       csr_penable      = 1'b0;
   logic                       csr_pwrite       = 1'b0;
   logic [CSR_ADDR_W-1:0]      csr_paddr        = '0;
   logic [CSR_DATA_W-1:0]      csr_pwdata       = '0;
   logic [CSR_DATA_W-1:0]      csr_prdata;
   logic                       csr_pready;

   int   failures;
   int   pending;
   int   results_seen;
   int   sent         = 0;
   int   tx_idle_pct  = 19;
   int   rx_idle_pct  = 73;
   int   quiet        = 0;
   int   series_left  = 0;
   int   series_mode  = 0;
   logic hold_trigger = 1'b0;
   logic signed [SAMPLE_W-1:0] last_sample = '0;

   sliding_window_min_max dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_first        (req_first),
      .req_final_sample (req_final_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_window_min   (rsp_window_min),
      .rsp_window_max   (rsp_window_max),
      .rsp_position     (rsp_position),
      .rsp_end_of_run   (rsp_end_of_run),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   swmm_window_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_first        (req_first),
      .req_final_sample (req_final_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_window_min   (rsp_window_min),
      .rsp_window_max   (rsp_window_max),
      .rsp_position     (rsp_position),
      .rsp_end_of_run   (rsp_end_of_run),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .failures         (failures),
      .pending          (pending),
      .results_seen     (results_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random stalls, or a long hold-off when asked for
   initial begin : result_sink
      int   hold_left;
      logic seen;
      hold_left = 0;
      seen      = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_trigger != seen) begin
            seen      = hold_trigger;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic push(input logic [SAMPLE_W-1:0] smp, input logic f, input logic l);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_sample       <= smp;
      req_first        <= f;
      req_final_sample <= l;
      do begin
         @(posedge clock);
      end while (req_stall);
      @(negedge clock);
      sent++;
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= ADDR_PERIOD;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // period changes only once the block has drained
   task automatic set_window(input logic [PERIOD_W-1:0] per);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (SETTLE) @(negedge clock);
      csr_access(1'b1, CSR_DATA_W'(per));
      csr_access(1'b0, '0);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(input int mode);
      case (mode)
         0: last_sample = $urandom;
         1: last_sample = $signed($urandom_range(6)) - 3;
         2: last_sample = last_sample + $urandom_range(1, 1000);
         3: last_sample = last_sample - $urandom_range(1, 1000);
         default: begin
            case ($urandom_range(5))
               0: last_sample = 32'sh8000_0000;
               1: last_sample = 32'sh7FFF_FFFF;
               2: last_sample = 32'sh8000_0001;
               3: last_sample = 32'sh7FFF_FFFE;
               4: last_sample = -32'sd1;
               default: last_sample = '0;
            endcase
         end
      endcase
      return last_sample;
   endfunction

   // mostly well-formed series (first ... final), a few broken markers
   task automatic run_phase(input logic [PERIOD_W-1:0] per, input int n,
                            input int tx_pct, input int rx_pct,
                            input bit fresh, input int hold_at);
      int   p;
      logic f;
      logic l;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      set_window(per);
      p = (per == '0) ? 1 : (per > MAX_PERIOD_DEF) ? MAX_PERIOD_DEF : int'(per);
      if (fresh)
         series_left = 0;
      for (int i = 0; i < n; i++) begin
         f = 1'b0;
         if (series_left == 0) begin
            f = 1'b1;
            if (p > 32 || $urandom_range(3) != 0)
               series_left = $urandom_range(p, 3 * p + 4);
            else
               series_left = $urandom_range(1, p);
            series_mode = $urandom_range(4);
         end
         l = (series_left == 1);
         series_left--;
         if ($urandom_range(11) == 0) begin
            f = 1'($urandom_range(1));
            l = 1'($urandom_range(1));
         end
         if (i == hold_at)
            hold_trigger <= ~hold_trigger;
         push(pick_sample(series_mode), f, l);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      csr_access(1'b0, '0);

      // corner samples, ties, expiry and early final marker at window 4
      set_window(9'd4);
      push(32'h7FFF_FFFF, 1'b1, 1'b0);
      push(32'h8000_0000, 1'b0, 1'b0);
      push(32'h8000_0000, 1'b0, 1'b1);
      push(32'hFFFF_FFFF, 1'b0, 1'b0);
      push(32'h0000_0000, 1'b0, 1'b0);
      push(32'd5, 1'b0, 1'b0);
      push(32'd5, 1'b0, 1'b0);
      push(32'd5, 1'b0, 1'b0);
      push(32'd5, 1'b0, 1'b1);
      push(-32'sd7, 1'b0, 1'b0);
      push(-32'sd7, 1'b0, 1'b0);
      push(32'h7FFF_FFFF, 1'b0, 1'b0);
      push(32'h8000_0000, 1'b0, 1'b0);
      push(32'd1, 1'b1, 1'b0);
      push(32'd2, 1'b0, 1'b0);
      push(32'd3, 1'b0, 1'b1);
      push(32'd4, 1'b0, 1'b0);
      // zero period behaves as a window of one
      set_window(9'd0);
      push(32'd9, 1'b0, 1'b0);
      push(32'h8000_0000, 1'b0, 1'b1);
      push(32'h7FFF_FFFF, 1'b1, 1'b1);

      run_phase(9'd1,   30, 19, 73, 1'b1, -1);
      run_phase(9'd9,   50, 19, 73, 1'b1, -1);
      run_phase(9'd511, 270, 73, 19, 1'b1, -1);
      run_phase(9'd256, 20, 73, 19, 1'b0, -1);
      run_phase(9'd30,  50, 0, 0, 1'b1, -1);
      run_phase(9'd2,   30, 0, 0, 1'b1, 5);

      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (SETTLE) @(negedge clock);

      $display("Run covered %0d requests and %0d window results", sent, results_seen);
      $display("Window lengths 0, 1, 2, 4, 9, 30, 256 and 511; one %0d-cycle output hold-off",
               HOLD_CYCLES);
      if (failures == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d failures, %0d results still due", failures, pending);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- sliding_window_min_max.f -----
rtl/swmm_pkg.sv
rtl/swmm_ring.sv
rtl/swmm_csr.sv
rtl/sliding_window_min_max.sv
dv/swmm_window_checker.sv
dv/tb_sliding_window_min_max.sv
